// File: src/fac_pkg.sv
// Shared types and constants for the frustum box culling block.
// No dependencies; imported by every module of the block.

package fac_pkg;

  // Configuration port.
  localparam int CFG_WIDTH     = 64;
  localparam int CFG_IDX_WIDTH = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_COL0 = 2'd0,
    REG_COL1 = 2'd1,
    REG_COL2 = 2'd2,
    REG_COL3 = 2'd3
  } fac_reg_t;

  // Identity matrix, 1.0 in Q4.12 on the diagonal.
  localparam logic [CFG_WIDTH-1:0] RESET_COL0 = 64'h0000_0000_0000_1000;
  localparam logic [CFG_WIDTH-1:0] RESET_COL1 = 64'h0000_0000_1000_0000;
  localparam logic [CFG_WIDTH-1:0] RESET_COL2 = 64'h0000_1000_0000_0000;
  localparam logic [CFG_WIDTH-1:0] RESET_COL3 = 64'h1000_0000_0000_0000;

  localparam int NUM_COLS     = 4;
  localparam int NUM_PLANES   = 6;
  localparam int DETAIL_WIDTH = 8;

  // The constant plane term is Q.12 and the products are Q.16.
  localparam int DC_SHIFT = 4;

  // Result beat layout.
  localparam int OUT_TDATA_WIDTH = 8;
  localparam int OUT_INSIDE_BIT  = 0;
  localparam int OUT_KEEP_BIT    = 1;

  // Control that travels with a box down the chain of plane cells.
  typedef struct packed {
    logic                    valid;
    logic                    in_view;
    logic [DETAIL_WIDTH-1:0] detail;
  } fac_ctl_t;

endpackage

// File: src/fac_cell.sv
// One plane cell: forms its plane from two matrix columns, picks the positive
// corner, evaluates the plane equation and folds the sign into the inside flag.
// Depends on fac_pkg.

module fac_cell import fac_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16,
  parameter bit NEG         = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic [NUM_COLS-1:0][COEF_WIDTH-1:0]  axis_col,
  input  logic [NUM_COLS-1:0][COEF_WIDTH-1:0]  w_col,
  input  fac_ctl_t                             in_ctl,
  input  logic [5:0][COORD_WIDTH-1:0]          in_box,
  output fac_ctl_t                             out_ctl,
  output logic [5:0][COORD_WIDTH-1:0]          out_box
);

  localparam int PW  = COEF_WIDTH + 1;
  localparam int PRW = PW + COORD_WIDTH;
  localparam int AW  = PRW + 2;

  logic signed [PW-1:0]          plane [NUM_COLS];
  logic signed [COORD_WIDTH-1:0] corner [3];
  logic signed [PRW-1:0]         prod_next [3];

  fac_ctl_t                    ctl1;
  logic [5:0][COORD_WIDTH-1:0] box1;
  logic signed [PRW-1:0]       prod1 [3];
  logic signed [PW-1:0]        dterm1;
  logic signed [AW-1:0]        sum;

  always_comb begin
    for (int r = 0; r < NUM_COLS; r++) begin
      if (NEG) begin
        plane[r] = PW'($signed(w_col[r])) - PW'($signed(axis_col[r]));
      end else begin
        plane[r] = PW'($signed(w_col[r])) + PW'($signed(axis_col[r]));
      end
    end
    // A non-negative coefficient takes the max side of the box.
    for (int r = 0; r < 3; r++) begin
      corner[r]    = plane[r][PW-1] ? $signed(in_box[r]) : $signed(in_box[r+3]);
      prod_next[r] = PRW'(plane[r]) * PRW'(corner[r]);
    end
  end

  always_comb begin
    sum = AW'(prod1[0]) + AW'(prod1[1]) + AW'(prod1[2]) + (AW'(dterm1) <<< DC_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid    <= 1'b0;
      out_ctl.valid <= 1'b0;
    end else if (adv) begin
      ctl1            <= in_ctl;
      box1            <= in_box;
      for (int r = 0; r < 3; r++) begin
        prod1[r] <= prod_next[r];
      end
      dterm1          <= plane[3];
      out_ctl.valid   <= ctl1.valid;
      out_ctl.in_view <= ctl1.in_view & ~sum[AW-1];
      out_ctl.detail  <= ctl1.detail;
      out_box         <= box1;
    end
  end

endmodule

// File: src/fac_out_buf.sv
// Result register with a skid stage so the chain can take one more beat while a
// result waits on the master side. Depends on fac_pkg.

module fac_out_buf import fac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_inside,
  input  logic                       in_keep,
  output logic                       in_ready,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  logic       res_valid;
  logic [1:0] res_data;
  logic       skid_valid;
  logic [1:0] skid_data;
  logic [1:0] in_data;
  logic       in_fire;
  logic       out_take;

  always_comb begin
    in_data                 = '0;
    in_data[OUT_INSIDE_BIT] = in_inside;
    in_data[OUT_KEEP_BIT]   = in_keep;
    in_fire                 = in_valid & ~skid_valid;
    out_take                = res_valid & m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (res_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        res_valid <= 1'b1;
      end
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        res_data <= skid_data;
      end
    end else if (in_fire) begin
      if (res_valid && !m_tready) begin
        skid_data <= in_data;
      end else begin
        res_data <= in_data;
      end
    end
  end

  assign in_ready = ~skid_valid;
  assign m_tvalid = res_valid;
  assign m_tdata  = OUT_TDATA_WIDTH'(res_data);

endmodule

// File: src/frustum_aabb_cull.sv
// Frustum culling of axis-aligned boxes by the positive-vertex test.
// Depends on fac_pkg, fac_cell and fac_out_buf.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  box min xyz, box max xyz, detail level
//   m_*      out  m_tvalid/m_tready  inside_res, keep
//   cfg_*    in   cfg_we             matrix column index, 64-bit column
//
// One box is accepted every cycle while s_tready is high; a box passes through
// six plane cells of two register stages each (multiply, then sum and sign),
// followed by the result register.
// Reset loads the identity matrix and empties the chain.
// When the master stalls, one more result lands in the skid stage; after that
// s_tready drops and the whole chain holds until the skid stage drains.

module frustum_aabb_cull import fac_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // detail_level, zero fill to a byte boundary
  input  logic [((6*COORD_WIDTH+DETAIL_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // inside_res, keep, zero fill
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  logic [NUM_COLS-1:0][CFG_WIDTH-1:0]                col;
  logic [NUM_COLS-1:0][NUM_COLS-1:0][COEF_WIDTH-1:0] entry;
  logic                                              adv;
  fac_ctl_t                                          ctl [NUM_PLANES+1];
  logic [5:0][COORD_WIDTH-1:0]                       box [NUM_PLANES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= RESET_COL0;
      col[1] <= RESET_COL1;
      col[2] <= RESET_COL2;
      col[3] <= RESET_COL3;
    end else if (cfg_we) begin
      case (fac_reg_t'(cfg_index))
        REG_COL0: col[0] <= cfg_data;
        REG_COL1: col[1] <= cfg_data;
        REG_COL2: col[2] <= cfg_data;
        REG_COL3: col[3] <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Matrix entries; bits past the end of a column register read as zero.
  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    for (genvar r = 0; r < NUM_COLS; r++) begin : g_row
      for (genvar b = 0; b < COEF_WIDTH; b++) begin : g_bit
        if (r * COEF_WIDTH + b < CFG_WIDTH) begin : g_in
          assign entry[c][r][b] = col[c][r*COEF_WIDTH+b];
        end else begin : g_out
          assign entry[c][r][b] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    ctl[0].valid   = s_tvalid;
    ctl[0].in_view = 1'b1;
    ctl[0].detail  = s_tdata[6*COORD_WIDTH +: DETAIL_WIDTH];
    for (int i = 0; i < 6; i++) begin
      box[0][i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // Planes in the order x+, x-, y+, y-, z+, z-.
  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
    fac_cell #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH),
      .NEG        ((k % 2) == 1)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .axis_col(entry[k/2]),
      .w_col   (entry[3]),
      .in_ctl  (ctl[k]),
      .in_box  (box[k]),
      .out_ctl (ctl[k+1]),
      .out_box (box[k+1])
    );
  end

  fac_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ctl[NUM_PLANES].valid),
    .in_inside(ctl[NUM_PLANES].in_view),
    .in_keep  (ctl[NUM_PLANES].in_view | (ctl[NUM_PLANES].detail != '0)),
    .in_ready (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  assign s_tready = adv;

endmodule

// File: src/fac_checker.sv
// Port-level checks for frustum_aabb_cull, attached by the bind below.
// Depends on fac_pkg.

module fac_checker import fac_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  // A result beat that is not taken stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result payload changed while stalled");

  // An inside box is always kept.
  a_inside_keep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_INSIDE_BIT] |-> m_tdata[OUT_KEEP_BIT])
    else $error("inside box not kept");

  // The input side only closes while a result is waiting.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // Reset leaves the block empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not empty after reset");

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
